FILE: sv/rk4_pkg.sv
// ----------------------------------------------------------------------------
// rk4_pkg
// Shared types, constants and helpers for the RK4 stage update block.
// ----------------------------------------------------------------------------
package rk4_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_ARRAY_DEPTH = 4096;
  localparam int DEF_VALUE_WIDTH = 32;

  // Fixed field widths
  localparam int FIELD_W = 32;
  localparam int IDX_W   = 12;
  localparam int OP_W    = 2;
  localparam int STEP_W  = 32;

  // Reset value of the step size register (h as unsigned Q0.32)
  localparam logic [STEP_W-1:0] STEP_RESET = 32'd1073742;

  // Input tdata layout, lowest bit up
  localparam int IN_TDATA_W  = 144;
  localparam int IN_IDX_LSB  = 0;
  localparam int IN_DRE_LSB  = 12;
  localparam int IN_DIM_LSB  = 44;
  localparam int IN_VRE_LSB  = 76;
  localparam int IN_VIM_LSB  = 108;

  // Output tdata layout, lowest bit up
  localparam int OUT_TDATA_W = 80;
  localparam int OUT_RE_LSB  = 0;
  localparam int OUT_IM_LSB  = 32;
  localparam int OUT_IDX_LSB = 64;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_IDX_LSB - IDX_W;

  // Index reduction is split over two stages at this shift
  localparam int RED_SPLIT = 6;

  // Stage codes
  typedef enum logic [OP_W-1:0] {
    OP_FIRST  = 2'd0,
    OP_SECOND = 2'd1,
    OP_THIRD  = 2'd2,
    OP_FINAL  = 2'd3
  } rk_op_t;

  // Selects one of the increment stores (first also covers the start value)
  typedef struct packed {
    logic first;
    logic second;
    logic third;
  } store_sel_t;

  // Control handed from the pipeline controller to each datapath lane
  typedef struct packed {
    rk_op_t     op1;
    rk_op_t     op2;
    rk_op_t     op4;
    store_sel_t wr;
    store_sel_t hit;
  } lane_ctl_t;

  // Partial reduction of an index modulo depth: conditional subtracts of
  // depth shifted by hi_s down to lo_s
  function automatic logic [IDX_W-1:0] idx_reduce(input logic [IDX_W-1:0] idx,
                                                  input int depth,
                                                  input int lo_s,
                                                  input int hi_s);
    logic [IDX_W-1:0] r;
    longint           lim;
    r = idx;
    for (int s = hi_s; s >= lo_s; s--) begin
      lim = longint'(depth) << s;
      if (lim <= longint'(r)) begin
        r = r - IDX_W'(lim);
      end
    end
    return r;
  endfunction

endpackage

FILE: sv/rk4_store.sv
// ----------------------------------------------------------------------------
// rk4_store
// Simple dual-port memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rk4_store #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/rk4_lane.sv
// ----------------------------------------------------------------------------
// rk4_lane
// Datapath for one part (real or imaginary): increment multiply, rounding,
// per-element stores with write forwarding, divide-by-six and saturation.
// ----------------------------------------------------------------------------
module rk4_lane import rk4_pkg::*; #(
  parameter int ARRAY_DEPTH = DEF_ARRAY_DEPTH,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
  parameter int ADDR_W      = 12
) (
  input  logic                   clk,
  input  logic                   adv,
  input  logic [VALUE_WIDTH-1:0] in_dy,
  input  logic [VALUE_WIDTH-1:0] in_y,
  input  logic [STEP_W-1:0]      step,
  input  lane_ctl_t              ctl,
  input  logic [ADDR_W-1:0]      rd_addr,
  input  logic [ADDR_W-1:0]      wr_addr,
  output logic [VALUE_WIDTH-1:0] res
);

  localparam int W    = VALUE_WIDTH;
  localparam int PW   = W + STEP_W + 1;     // product width
  localparam int SW   = W + 3;              // final-stage sum width
  localparam int TW   = W + 5;              // biased sum width
  localparam int AWD  = W + 4;              // halved biased sum width
  localparam int SPL  = 2 * ((W + 7) / 4);  // even split point of the dividend
  localparam int AHW  = AWD - SPL;
  localparam int BW   = SPL + 1;
  localparam int MW   = SPL + 2;
  localparam int SH   = SPL + 3;
  localparam int RW   = W + 6;              // result width before saturation

  // (2^SPL - 1) / 3, and a reciprocal of 3 exact for BW-bit operands
  localparam logic [SPL-1:0] C1   = SPL'(((64'd1 << SPL) - 64'd1) / 64'd3);
  localparam logic [MW-1:0]  MREC = MW'(((64'd1 << SH) + 64'd1) / 64'd3);
  // 6 * 2^(W+2) + 3 : keeps the dividend positive
  localparam logic [TW-1:0]  T_OFS = TW'((64'd3 << (W + 3)) + 64'd3);
  localparam logic signed [RW-1:0] BIAS   = RW'(64'd1 << (W + 2));
  localparam logic signed [RW-1:0] SAT_HI = RW'((64'd1 << (W - 1)) - 64'd1);
  localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);
  localparam logic signed [PW-1:0] RND    = PW'(64'h8000_0000);

  // ---- stage 0: input registers, multiply ----
  logic signed [W-1:0]  dy0_r, y0_r;
  logic signed [32:0]   h_s;
  logic signed [PW-1:0] prod_c;

  always_ff @(posedge clk) begin
    if (adv) begin
      dy0_r <= in_dy;
      y0_r  <= in_y;
    end
  end

  assign h_s    = {1'b0, step};
  assign prod_c = dy0_r * h_s;

  // ---- stage 1: round increment, write stores, forward ----
  logic signed [PW-1:0] prod1_r;
  logic signed [W-1:0]  y1_r, fwd_y_r, fwd_k_r;
  logic signed [PW-1:0] rnd_c;
  logic signed [W-1:0]  k_c;
  logic [W-1:0]         rd_start, rd_ka, rd_kb, rd_kc;
  logic signed [W-1:0]  m_start, m_ka, m_kb, m_kc, base_c;

  always_ff @(posedge clk) begin
    if (adv) begin
      prod1_r <= prod_c;
      y1_r    <= y0_r;
      // writer data seen at the read edge, for the younger item's bypass
      fwd_y_r <= y1_r;
      fwd_k_r <= k_c;
    end
  end

  assign rnd_c = prod1_r + RND;
  assign k_c   = rnd_c[W+31:32];

  rk4_store #(.DEPTH(ARRAY_DEPTH), .ADDR_W(ADDR_W), .DATA_W(W)) u_start (
    .clk(clk), .wr_en(ctl.wr.first), .wr_addr(wr_addr), .wr_data(y1_r),
    .rd_en(adv), .rd_addr(rd_addr), .rd_data(rd_start)
  );
  rk4_store #(.DEPTH(ARRAY_DEPTH), .ADDR_W(ADDR_W), .DATA_W(W)) u_incr_one (
    .clk(clk), .wr_en(ctl.wr.first), .wr_addr(wr_addr), .wr_data(k_c),
    .rd_en(adv), .rd_addr(rd_addr), .rd_data(rd_ka)
  );
  rk4_store #(.DEPTH(ARRAY_DEPTH), .ADDR_W(ADDR_W), .DATA_W(W)) u_incr_two (
    .clk(clk), .wr_en(ctl.wr.second), .wr_addr(wr_addr), .wr_data(k_c),
    .rd_en(adv), .rd_addr(rd_addr), .rd_data(rd_kb)
  );
  rk4_store #(.DEPTH(ARRAY_DEPTH), .ADDR_W(ADDR_W), .DATA_W(W)) u_incr_three (
    .clk(clk), .wr_en(ctl.wr.third), .wr_addr(wr_addr), .wr_data(k_c),
    .rd_en(adv), .rd_addr(rd_addr), .rd_data(rd_kc)
  );

  // bypass the write that landed on the same edge as our read
  assign m_start = ctl.hit.first  ? fwd_y_r : rd_start;
  assign m_ka    = ctl.hit.first  ? fwd_k_r : rd_ka;
  assign m_kb    = ctl.hit.second ? fwd_k_r : rd_kb;
  assign m_kc    = ctl.hit.third  ? fwd_k_r : rd_kc;
  assign base_c  = (ctl.op1 == OP_FIRST) ? y1_r : m_start;

  // ---- stage 2: halving, weighted sum, bias ----
  logic signed [W-1:0]  k2_r, base2_r, ka2_r, kb2_r, kc2_r;
  logic signed [W:0]    kp1_c, half_c, addend_c;
  logic signed [SW-1:0] sum_c;
  logic [TW-1:0]        t_c;

  always_ff @(posedge clk) begin
    if (adv) begin
      k2_r    <= k_c;
      base2_r <= base_c;
      ka2_r   <= m_ka;
      kb2_r   <= m_kb;
      kc2_r   <= m_kc;
    end
  end

  assign kp1_c    = {k2_r[W-1], k2_r} + (W+1)'(1);
  assign half_c   = kp1_c >>> 1;
  assign addend_c = (ctl.op2 == OP_THIRD) ? {k2_r[W-1], k2_r} : half_c;
  assign sum_c    = SW'(ka2_r) + (SW'(kb2_r) <<< 1) + (SW'(kc2_r) <<< 1) + SW'(k2_r);
  assign t_c      = TW'(sum_c) + T_OFS;

  // ---- stage 3: divide by three as two partial products ----
  logic [AWD-1:0]       a3_r;
  logic signed [W:0]    addend3_r;
  logic signed [W-1:0]  base3_r;
  logic [AHW-1:0]       ah_c;
  logic [SPL-1:0]       al_c;
  logic [BW-1:0]        b_c;
  logic [AWD-1:0]       ph_c;
  logic [BW+MW-1:0]     pl_c;

  always_ff @(posedge clk) begin
    if (adv) begin
      a3_r      <= t_c[TW-1:1];
      addend3_r <= addend_c;
      base3_r   <= base2_r;
    end
  end

  assign ah_c = a3_r[AWD-1:SPL];
  assign al_c = a3_r[SPL-1:0];
  assign b_c  = BW'(ah_c) + BW'(al_c);
  assign ph_c = ah_c * C1;
  assign pl_c = b_c * MREC;

  // ---- stage 4: sixth, final add, saturate ----
  logic [AWD-1:0]       ph4_r;
  logic [BW+MW-1:0]     pl4_r;
  logic signed [W:0]    addend4_r;
  logic signed [W-1:0]  base4_r;
  logic [AWD-1:0]       q_c;
  logic signed [RW-1:0] sixth_c, sel_c, total_c;
  logic [W-1:0]         res_c;
  logic [W-1:0]         res_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ph4_r     <= ph_c;
      pl4_r     <= pl_c;
      addend4_r <= addend3_r;
      base4_r   <= base3_r;
    end
  end

  assign q_c     = ph4_r + AWD'(pl4_r >> SH);
  assign sixth_c = signed'(RW'(q_c)) - BIAS;
  assign sel_c   = (ctl.op4 == OP_FINAL) ? sixth_c : RW'(addend4_r);
  assign total_c = RW'(base4_r) + sel_c;

  always_comb begin
    if (total_c > SAT_HI) begin
      res_c = SAT_HI[W-1:0];
    end else if (total_c < SAT_LO) begin
      res_c = SAT_LO[W-1:0];
    end else begin
      res_c = total_c[W-1:0];
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_c;
    end
  end

  assign res = res_r;

endmodule

FILE: sv/rk4_stage_update.sv
// ----------------------------------------------------------------------------
// rk4_stage_update
// Fourth-order Runge-Kutta stage update for one complex element per
// transaction, with per-element start value and increment stores.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  in_      slave      in_tvalid/in_tready  in_tdata, in_tuser (stage)
//  out_     master     out_tvalid/out_tready out_tdata
//  cfg_     slave      cfg_valid/cfg_ready  cfg_data (step size)
//
//  One transaction per cycle while the output is not stalled; a result is
//  registered through the input register, multiply, rounding and store write, sum,
//  divide-by-three products and output register.
//  A result held in the output register with out_tready low freezes every
//  stage together, the stores included; in_tready drops while it is held.
//  Reset clears valid bits and loads the step size; the stores are not
//  cleared and hold nothing until written.
//
module rk4_stage_update import rk4_pkg::*; #(
  parameter int ARRAY_DEPTH = DEF_ARRAY_DEPTH,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // slave stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // elem_index[11:0], deriv_re[43:12], deriv_im[75:44],
  // value_re[107:76], value_im[139:108], zero pad[143:140]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // op[1:0]
  input  logic [OP_W-1:0]        in_tuser,
  // master stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // new_re[31:0], new_im[63:32], out_index[75:64], zero pad[79:76]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // configuration
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [STEP_W-1:0]      cfg_data
);

  localparam int ADDR_W = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1;

  // ---- step size register ----
  logic [STEP_W-1:0] step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RESET;
    end else if (cfg_valid) begin
      step_r <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;

  // ---- pipeline advance ----
  logic adv;
  logic out_v_r;

  assign adv       = !out_v_r || out_tready;
  assign in_tready = adv;

  // ---- stage 0: capture, first half of index reduction ----
  logic [IDX_W-1:0] in_idx, rpart_c;
  logic             v0_r;
  rk_op_t           op0_r;
  logic [IDX_W-1:0] idx0_r, rpart0_r;
  logic [ADDR_W-1:0] addr0_c;

  assign in_idx  = in_tdata[IN_IDX_LSB +: IDX_W];
  assign rpart_c = idx_reduce(in_idx, ARRAY_DEPTH, RED_SPLIT, IDX_W - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op0_r    <= rk_op_t'(in_tuser);
      idx0_r   <= in_idx;
      rpart0_r <= rpart_c;
    end
  end

  assign addr0_c = ADDR_W'(idx_reduce(rpart0_r, ARRAY_DEPTH, 0, RED_SPLIT - 1));

  // ---- stage 1: store writes and read-edge bypass detection ----
  logic              v1_r;
  rk_op_t            op1_r;
  logic [IDX_W-1:0]  idx1_r;
  logic [ADDR_W-1:0] waddr1_r;
  store_sel_t        hit1_r, hit_nxt, wr_c;
  logic              match_c;

  always_comb begin
    wr_c.first  = adv && v1_r && (op1_r == OP_FIRST);
    wr_c.second = adv && v1_r && (op1_r == OP_SECOND);
    wr_c.third  = adv && v1_r && (op1_r == OP_THIRD);
  end

  assign match_c = v1_r && (waddr1_r == addr0_c);

  always_comb begin
    hit_nxt.first  = match_c && (op1_r == OP_FIRST);
    hit_nxt.second = match_c && (op1_r == OP_SECOND);
    hit_nxt.third  = match_c && (op1_r == OP_THIRD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      hit1_r <= '0;
    end else if (adv) begin
      v1_r   <= v0_r;
      hit1_r <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1_r    <= op0_r;
      idx1_r   <= idx0_r;
      waddr1_r <= addr0_c;
    end
  end

  // ---- stages 2 to 4: control shift ----
  logic             v2_r, v3_r, v4_r;
  rk_op_t           op2_r, op3_r, op4_r;
  logic [IDX_W-1:0] idx2_r, idx3_r, idx4_r, out_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      v4_r    <= v3_r;
      out_v_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op2_r     <= op1_r;
      op3_r     <= op2_r;
      op4_r     <= op3_r;
      idx2_r    <= idx1_r;
      idx3_r    <= idx2_r;
      idx4_r    <= idx3_r;
      out_idx_r <= idx4_r;
    end
  end

  // ---- lanes ----
  lane_ctl_t              ctl;
  logic [VALUE_WIDTH-1:0] res_re, res_im;

  always_comb begin
    ctl.op1 = op1_r;
    ctl.op2 = op2_r;
    ctl.op4 = op4_r;
    ctl.wr  = wr_c;
    ctl.hit = hit1_r;
  end

  rk4_lane #(.ARRAY_DEPTH(ARRAY_DEPTH), .VALUE_WIDTH(VALUE_WIDTH), .ADDR_W(ADDR_W)) u_re (
    .clk(clk), .adv(adv),
    .in_dy(in_tdata[IN_DRE_LSB +: VALUE_WIDTH]),
    .in_y(in_tdata[IN_VRE_LSB +: VALUE_WIDTH]),
    .step(step_r), .ctl(ctl), .rd_addr(addr0_c), .wr_addr(waddr1_r), .res(res_re)
  );

  rk4_lane #(.ARRAY_DEPTH(ARRAY_DEPTH), .VALUE_WIDTH(VALUE_WIDTH), .ADDR_W(ADDR_W)) u_im (
    .clk(clk), .adv(adv),
    .in_dy(in_tdata[IN_DIM_LSB +: VALUE_WIDTH]),
    .in_y(in_tdata[IN_VIM_LSB +: VALUE_WIDTH]),
    .step(step_r), .ctl(ctl), .rd_addr(addr0_c), .wr_addr(waddr1_r), .res(res_im)
  );

  // ---- output ----
  assign out_tvalid = out_v_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_idx_r,
                       FIELD_W'(signed'(res_im)), FIELD_W'(signed'(res_re))};

`ifndef SYNTHESIS
  // at most one store written per cycle
  a_wr_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(wr_c)) else $error("rk4: more than one store written");

  // a bypass selects at most one store
  a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit1_r)) else $error("rk4: bypass hits several stores");

  // a bypass always stems from a real writer, now one stage ahead
  a_hit_writer: assert property (@(posedge clk) disable iff (!rst_n)
    (|hit1_r) |-> v2_r) else $error("rk4: bypass without writer");

  // nothing is written while the pipeline is frozen
  a_no_wr_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_tready) |-> !(|wr_c)) else $error("rk4: write during stall");
`endif

endmodule

FILE: tb/sv/rk4_stage_checker.sv
// ----------------------------------------------------------------------------
// rk4_stage_checker
// Watches the input, result and step-size channels of the RK4 stage update
// block, predicts every update from its own copy of the per-element stores
// and compares each result transaction field by field, in order.
// ----------------------------------------------------------------------------
module rk4_stage_checker import rk4_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [OP_W-1:0]        in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [STEP_W-1:0]      cfg_data,
  output int                     errors,
  output int                     pending,
  output int                     checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 100;

  // One expected update
  typedef struct packed {
    logic [FIELD_W-1:0] re;
    logic [FIELD_W-1:0] im;
    logic [IDX_W-1:0]   idx;
  } rk_update_t;

  rk_update_t        update_q[$];
  logic [STEP_W-1:0] step_h;

  // Per-element stores, [element][0 = real, 1 = imaginary]
  logic signed [FIELD_W-1:0] start_mem [DEF_ARRAY_DEPTH][2];
  logic signed [FIELD_W-1:0] k1_mem    [DEF_ARRAY_DEPTH][2];
  logic signed [FIELD_W-1:0] k2_mem    [DEF_ARRAY_DEPTH][2];
  logic signed [FIELD_W-1:0] k3_mem    [DEF_ARRAY_DEPTH][2];

  initial begin
    errors  = 0;
    pending = 0;
    checked = 0;
    step_h  = STEP_RESET;
  end

  // k = round(dy * h / 2^32), half rounded upwards
  function automatic longint scaled_incr(logic signed [FIELD_W-1:0] dy,
                                         logic [STEP_W-1:0] h);
    longint prod;
    prod = longint'(dy) * longint'({32'd0, h});
    return (prod + 64'sd2147483648) >>> 32;
  endfunction

  // floor((k + 1) / 2)
  function automatic longint half_up(longint k);
    return (k + 1) >>> 1;
  endfunction

  // floor((s + 3) / 6); division truncates towards zero, so fix negatives
  function automatic longint sixth_floor(longint s);
    longint n;
    longint q;
    n = s + 3;
    q = n / 6;
    if ((n % 6 != 0) && (n < 0)) begin
      q = q - 1;
    end
    return q;
  endfunction

  function automatic logic [FIELD_W-1:0] clip(longint v);
    if (v > 64'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[FIELD_W-1:0];
  endfunction

  // One part (real or imaginary) of one stage, updating the stores
  function automatic logic [FIELD_W-1:0] part_update(rk_op_t op, int ix, int p,
                                                     logic signed [FIELD_W-1:0] dy,
                                                     logic signed [FIELD_W-1:0] y);
    longint k;
    longint r;
    k = scaled_incr(dy, step_h);
    case (op)
      OP_FIRST: begin
        start_mem[ix][p] = y;
        k1_mem[ix][p]    = k[FIELD_W-1:0];
        r = longint'(y) + half_up(k);
      end
      OP_SECOND: begin
        k2_mem[ix][p] = k[FIELD_W-1:0];
        r = longint'(start_mem[ix][p]) + half_up(k);
      end
      OP_THIRD: begin
        k3_mem[ix][p] = k[FIELD_W-1:0];
        r = longint'(start_mem[ix][p]) + k;
      end
      default: begin
        r = longint'(start_mem[ix][p]) +
            sixth_floor(longint'(k1_mem[ix][p]) + 2 * longint'(k2_mem[ix][p]) +
                        2 * longint'(k3_mem[ix][p]) + k);
      end
    endcase
    return clip(r);
  endfunction

  task automatic report_error(string msg);
    if (errors < MAX_REPORTS) begin
      $display("%0t ns: mismatch: %s", $realtime, msg);
    end
    errors++;
  endtask

  // Sample every channel at the rising edge
  always @(posedge clk) begin : watch
    rk_update_t want;
    rk_update_t got;
    rk_op_t     op;
    int         ix;
    if (!rst_n) begin
      step_h = STEP_RESET;
      update_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        step_h = cfg_data;
      end
      // result transaction against the oldest expectation
      if (out_tvalid && out_tready) begin
        got.re  = out_tdata[OUT_RE_LSB +: FIELD_W];
        got.im  = out_tdata[OUT_IM_LSB +: FIELD_W];
        got.idx = out_tdata[OUT_IDX_LSB +: IDX_W];
        if (update_q.size() == 0) begin
          report_error($sformatf("result for index %0d with nothing expected", got.idx));
        end else begin
          want = update_q.pop_front();
          checked++;
          if (got.idx !== want.idx) begin
            report_error($sformatf("out_index got %h, expected %h", got.idx, want.idx));
          end
          if (got.re !== want.re) begin
            report_error($sformatf("new_re (index %0d) got %h, expected %h",
                                   want.idx, got.re, want.re));
          end
          if (got.im !== want.im) begin
            report_error($sformatf("new_im (index %0d) got %h, expected %h",
                                   want.idx, got.im, want.im));
          end
        end
      end
      // input transaction: predict its update
      if (in_tvalid && in_tready) begin
        op       = rk_op_t'(in_tuser);
        want.idx = in_tdata[IN_IDX_LSB +: IDX_W];
        ix       = int'(want.idx) % DEF_ARRAY_DEPTH;
        want.re  = part_update(op, ix, 0, in_tdata[IN_DRE_LSB +: FIELD_W],
                               in_tdata[IN_VRE_LSB +: FIELD_W]);
        want.im  = part_update(op, ix, 1, in_tdata[IN_DIM_LSB +: FIELD_W],
                               in_tdata[IN_VIM_LSB +: FIELD_W]);
        update_q.push_back(want);
      end
      pending = update_q.size();
    end
  end

endmodule

FILE: tb/sv/tb_rk4_stage_update.sv
// ----------------------------------------------------------------------------
// tb_rk4_stage_update
// Drives the RK4 stage update block with directed stage passes at the field
// extremes, then random well-formed stage passes mixed with stray stages,
// under several step sizes and idling patterns; the checker judges results.
// ----------------------------------------------------------------------------
module tb_rk4_stage_update import rk4_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 10;
  localparam int IN_PAD_W       = IN_TDATA_W - IN_VIM_LSB - FIELD_W;

  localparam logic [FIELD_W-1:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [FIELD_W-1:0] NEG_MAX = 32'h8000_0000;
  localparam logic [FIELD_W-1:0] ALL_ONE = 32'hFFFF_FFFF;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [OP_W-1:0]        in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [STEP_W-1:0]      cfg_data;

  int errors;
  int pending;
  int checked;

  // Stimulus bookkeeping
  int sender_idle_pct;
  int recv_stall_pct;
  bit long_hold_req;
  int items_sent;
  int step_writes;
  int quiet_cycles;

  // Which stores each element has had written
  bit started [DEF_ARRAY_DEPTH];
  bit has_k2  [DEF_ARRAY_DEPTH];
  bit has_k3  [DEF_ARRAY_DEPTH];

  rk4_stage_update dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  rk4_stage_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .errors     (errors),
    .pending    (pending),
    .checked    (checked)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Watchdog: too long without any transaction ends the run
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
                 (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left  = 0;
    hold_done  = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (long_hold_req && !hold_done) begin
        hold_done  = 1'b1;
        hold_left  = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Data word: extremes, small values around zero, or full range
  function automatic logic [FIELD_W-1:0] pick_word();
    logic [FIELD_W-1:0] w;
    w = $urandom;
    case ($urandom_range(9))
      0: return POS_MAX;
      1: return NEG_MAX;
      2: return '0;
      3, 4: return {{6{w[25]}}, w[25:0]};
      default: return w;
    endcase
  endfunction

  // Indexes: often from a small pool so stages of one element sit close
  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(99) < 40) begin
      return IDX_W'($urandom_range(15));
    end
    return IDX_W'($urandom);
  endfunction

  // Never let a stage read a store entry that was never written
  function automatic rk_op_t permitted_op(rk_op_t op, logic [IDX_W-1:0] idx);
    case (op)
      OP_SECOND, OP_THIRD: return started[idx] ? op : OP_FIRST;
      OP_FINAL: return (started[idx] && has_k2[idx] && has_k3[idx]) ? op : OP_FIRST;
      default: return OP_FIRST;
    endcase
  endfunction

  // Offer one transaction at the falling edge and hold it until taken
  task automatic push_item(rk_op_t op, logic [IDX_W-1:0] idx,
                           logic [FIELD_W-1:0] dre, logic [FIELD_W-1:0] dim,
                           logic [FIELD_W-1:0] vre, logic [FIELD_W-1:0] vim);
    while ((sender_idle_pct > 0) && ($urandom_range(99) < sender_idle_pct)) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{IN_PAD_W{1'b0}}, vim, vre, dim, dre, idx};
    do begin
      @(posedge clk);
    end while (!in_tready);
    case (op)
      OP_FIRST:  started[idx] = 1'b1;
      OP_SECOND: has_k2[idx]  = 1'b1;
      OP_THIRD:  has_k3[idx]  = 1'b1;
      default: ;
    endcase
    items_sent++;
    @(negedge clk);
  endtask

  // Step size write, only once every update has come back
  task automatic write_step(logic [STEP_W-1:0] h);
    in_tvalid <= 1'b0;
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= h;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    step_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly complete stage passes over a batch, some stray stages
  task automatic run_random(int n_items);
    int               done;
    int               nb;
    int               nn;
    logic [IDX_W-1:0] batch [8];
    logic [IDX_W-1:0] ix;
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(99) < 80) begin
        nb = $urandom_range(1, 8);
        for (int e = 0; e < nb; e++) begin
          batch[e] = pick_index();
        end
        for (int s = 0; s < 4; s++) begin
          for (int e = 0; e < nb; e++) begin
            push_item(permitted_op(rk_op_t'(s), batch[e]), batch[e],
                      pick_word(), pick_word(), pick_word(), pick_word());
            done++;
          end
        end
      end else begin
        nn = $urandom_range(1, 6);
        repeat (nn) begin
          ix = pick_index();
          push_item(permitted_op(rk_op_t'($urandom_range(3)), ix), ix,
                    pick_word(), pick_word(), pick_word(), pick_word());
          done++;
        end
      end
    end
  endtask

  // Main sequence
  initial begin
    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    in_tuser        = OP_FIRST;
    cfg_valid       = 1'b0;
    cfg_data        = '0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    long_hold_req   = 1'b0;
    items_sent      = 0;
    step_writes     = 0;
    // reset held, then released at a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed at the reset step size: saturation on the first stage,
    // both ends of the index range, alternating bit patterns
    push_item(OP_FIRST,  12'd0, POS_MAX, POS_MAX, POS_MAX, NEG_MAX);
    push_item(OP_SECOND, 12'd0, NEG_MAX, POS_MAX, '0, '0);
    push_item(OP_THIRD,  12'd0, '0, NEG_MAX, '0, '0);
    push_item(OP_FINAL,  12'd0, POS_MAX, NEG_MAX, '0, '0);
    push_item(OP_FIRST,  12'hFFF, NEG_MAX, NEG_MAX, NEG_MAX, POS_MAX);
    push_item(OP_SECOND, 12'hFFF, POS_MAX, NEG_MAX, ALL_ONE, ALL_ONE);
    push_item(OP_THIRD,  12'hFFF, NEG_MAX, POS_MAX, ALL_ONE, ALL_ONE);
    push_item(OP_FINAL,  12'hFFF, POS_MAX, ALL_ONE, ALL_ONE, ALL_ONE);
    push_item(OP_FIRST,  12'hAAA, 32'h5555_5555, 32'hAAAA_AAAA,
              32'hAAAA_AAAA, 32'h5555_5555);
    push_item(OP_FIRST,  12'h555, ALL_ONE, 32'd1, '0, ALL_ONE);

    // Directed at full-scale h: increments near the field limits,
    // saturation on the later stages and rounding of small negatives
    write_step(ALL_ONE);
    push_item(OP_FIRST,  12'd1, POS_MAX, POS_MAX, POS_MAX, POS_MAX);
    push_item(OP_SECOND, 12'd1, POS_MAX, NEG_MAX, '0, '0);
    push_item(OP_THIRD,  12'd1, POS_MAX, NEG_MAX, '0, '0);
    push_item(OP_FINAL,  12'd1, POS_MAX, NEG_MAX, '0, '0);
    push_item(OP_FIRST,  12'd2, NEG_MAX, NEG_MAX, '0, '0);
    push_item(OP_SECOND, 12'd2, NEG_MAX, POS_MAX, '0, '0);
    push_item(OP_THIRD,  12'd2, NEG_MAX, NEG_MAX, '0, '0);
    push_item(OP_FINAL,  12'd2, ALL_ONE, 32'd1, '0, '0);

    // Random phases under different step sizes and idling
    write_step('0);
    run_random(100);

    write_step(STEP_W'($urandom));
    sender_idle_pct = 62;
    run_random(250);

    write_step(ALL_ONE);
    sender_idle_pct = 0;
    recv_stall_pct  = 62;
    run_random(250);

    write_step(STEP_RESET);
    sender_idle_pct = 32;
    recv_stall_pct  = 32;
    run_random(250);

    // Back-pressure: long hold-off on the result side while items keep coming
    write_step(STEP_W'($urandom));
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    long_hold_req   = 1'b1;
    run_random(200);

    write_step(STEP_W'($urandom_range(1, 65535)));
    run_random(230);

    // Drain and verdict
    in_tvalid <= 1'b0;
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Run covered %0d input transactions, %0d results compared, %0d errors.",
             items_sent, checked, errors);
    $display("Step sizes written %0d times (zero, full scale, reset value, random); %s",
             step_writes, "idle-free, sender, receiver, mixed and hold-off phases.");
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
